>>> src/rgb_laplacian_3x3_filter_assert.svh
// ----------------------------------------------------------------------------
// rgb_laplacian_3x3_filter assertion macros
// Shared property forms for the filter's checker, clocked on clk and
// disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RGB_LAPLACIAN_3X3_FILTER_ASSERT_SVH
`define RGB_LAPLACIAN_3X3_FILTER_ASSERT_SVH

// condition holds in the same cycle
`define RGBLAP_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rgblap: same-cycle check failed");

// condition holds in the following cycle
`define RGBLAP_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rgblap: next-cycle check failed");

`endif

>>> src/rgblap_pkg.sv
// ----------------------------------------------------------------------------
// rgblap_pkg
// Types, codes and helper functions for the RGB 3x3 Laplacian filter.
// ----------------------------------------------------------------------------
package rgblap_pkg;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int NSUM_W     = 11;
  localparam int SUM_W      = 17;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int WEIGHT_W   = 6;
  localparam int OQ_DEPTH   = 8;
  localparam int OQ_PTR_W   = 3;
  localparam int OQ_CNT_W   = 4;

  localparam logic [CFG_DATA_W-1:0] RESET_IMAGE_WIDTH  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] RESET_IMAGE_HEIGHT = 11'd480;
  localparam logic [WEIGHT_W-1:0]   RESET_CENTRE_WEIGHT    = 6'b111000;
  localparam logic [WEIGHT_W-1:0]   RESET_NEIGHBOUR_WEIGHT = 6'b000001;

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = -6'sd16;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 6'sd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_CENTRE_WEIGHT,
    REG_NEIGHBOUR_WEIGHT
  } reg_index_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_t;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } tap_mask_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] red;
    logic signed [SUM_W-1:0] green;
    logic signed [SUM_W-1:0] blue;
    logic                    last;
  } result_t;

  function automatic logic signed [WEIGHT_W-1:0] sat_weight(input logic [WEIGHT_W-1:0] bits);
    logic signed [WEIGHT_W-1:0] v;
    v = $signed(bits);
    if (v < WEIGHT_MIN) begin
      return WEIGHT_MIN;
    end else if (v > WEIGHT_MAX) begin
      return WEIGHT_MAX;
    end
    return v;
  endfunction

  // channel 0 red, 1 green, 2 blue
  function automatic logic [CH_W-1:0] chan_of(input pix_t p, input int unsigned ch);
    return p[(2 - ch) * CH_W +: CH_W];
  endfunction

endpackage

>>> src/rgblap_ram.sv
// ----------------------------------------------------------------------------
// rgblap_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rgblap_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/rgblap_fifo.sv
// ----------------------------------------------------------------------------
// rgblap_fifo
// Small register queue holding finished results until they are taken.
// ----------------------------------------------------------------------------
module rgblap_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rgblap_pkg::result_t push_data,
  input  logic                pop,
  output rgblap_pkg::result_t head,
  output logic                not_empty
);

  rgblap_pkg::result_t                    entries [rgblap_pkg::OQ_DEPTH];
  logic [rgblap_pkg::OQ_PTR_W-1:0] wr_ptr;
  logic [rgblap_pkg::OQ_PTR_W-1:0] rd_ptr;
  logic [rgblap_pkg::OQ_CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);

endmodule

>>> src/rgb_laplacian_3x3_filter.sv
// ----------------------------------------------------------------------------
// rgb_laplacian_3x3_filter
// Streaming 3x3 symmetric convolution of an RGB raster, Laplacian by default.
// ----------------------------------------------------------------------------
// Takes one request per clock, pixels in raster order, and gives each pixel's
// three signed channel sums once the pixel one row and one column further on
// has arrived; after the frame's last pixel, flush requests push out the
// remaining saturated image width + 1 results, the final one marked by frame_last.
// The rate of one request per cycle is set by the line buffer RAM, read at
// acceptance and written back in the next cycle at the same column; a result
// passes through stages 1, 2 and 3, and up to eight results wait in an
// output queue, so output stalls only hold the input once that queue is
// committed. The line buffers need no clearing pass after reset. Writing the
// image size restarts the frame; configure only while the block is idle.
// ----------------------------------------------------------------------------
module rgb_laplacian_3x3_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [rgblap_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rgblap_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   kind,
  input  logic [rgblap_pkg::CH_W-1:0]            red_in,
  input  logic [rgblap_pkg::CH_W-1:0]            green_in,
  input  logic [rgblap_pkg::CH_W-1:0]            blue_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [rgblap_pkg::SUM_W-1:0]    red_sum,
  output logic signed [rgblap_pkg::SUM_W-1:0]    green_sum,
  output logic signed [rgblap_pkg::SUM_W-1:0]    blue_sum,
  output logic                                   frame_last
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int WS_W  = ($clog2(MAX_WIDTH + 1) > rgblap_pkg::CFG_DATA_W) ?
                         $clog2(MAX_WIDTH + 1) : rgblap_pkg::CFG_DATA_W;
  localparam int HS_W  = (ROW_W > rgblap_pkg::CFG_DATA_W) ? ROW_W : rgblap_pkg::CFG_DATA_W;
  localparam logic [WS_W-1:0] W_MAX = WS_W'(MAX_WIDTH);
  localparam logic [WS_W-1:0] W_MIN = WS_W'(2);
  localparam logic [HS_W-1:0] H_MAX = HS_W'(MAX_HEIGHT);
  localparam logic [HS_W-1:0] H_MIN = HS_W'(2);
  localparam int PROD_W = rgblap_pkg::SUM_W + 1;

  // configuration
  logic [rgblap_pkg::CFG_DATA_W-1:0] image_width;
  logic [rgblap_pkg::CFG_DATA_W-1:0] image_height;
  logic [rgblap_pkg::WEIGHT_W-1:0]   centre_weight;
  logic [rgblap_pkg::WEIGHT_W-1:0]   neighbour_weight;
  logic                              size_write;

  // positions
  logic [COL_W-1:0] in_column;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] out_column;
  logic [ROW_W-1:0] out_row;

  logic [WS_W-1:0] width_raw, w_eff, in_col_inc, out_col_inc;
  logic [HS_W-1:0] height_raw, h_eff, in_row_ext, out_row_inc;
  logic            take, in_frame, active, emit, in_col_wrap;
  rgblap_pkg::tap_mask_t mask;
  logic            last;

  // output queue credit
  logic [rgblap_pkg::OQ_CNT_W-1:0] credit;
  logic                            pop;

  // pipeline
  logic                  p1_valid, p1_pixel, p1_emit, p1_last;
  rgblap_pkg::tap_mask_t p1_mask;
  rgblap_pkg::pix_t      p1_pix;
  logic [COL_W-1:0]      p1_col;
  rgblap_pkg::pix_t      rd_upper, rd_lower;
  logic                  store_we;

  rgblap_pkg::pix_t      window_regs [9];
  rgblap_pkg::pix_t      col_in [3];

  logic                  p2_valid, p2_last;
  rgblap_pkg::tap_mask_t p2_mask;
  logic [rgblap_pkg::NSUM_W-1:0] nsum [3];
  logic                  tap_use;

  logic                          p3_valid, p3_last;
  logic [rgblap_pkg::NSUM_W-1:0] p3_nsum [3];
  logic [rgblap_pkg::CH_W-1:0]   p3_centre [3];

  logic signed [rgblap_pkg::WEIGHT_W-1:0] cw, nw;
  logic signed [PROD_W-1:0]               prod_c [3];
  logic signed [PROD_W-1:0]               prod_n [3];
  logic signed [PROD_W-1:0]               total [3];
  rgblap_pkg::result_t                    push_data, head;

  assign size_write = cfg_write &&
                      (cfg_index == rgblap_pkg::REG_IMAGE_WIDTH ||
                       cfg_index == rgblap_pkg::REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= rgblap_pkg::RESET_IMAGE_WIDTH;
      image_height     <= rgblap_pkg::RESET_IMAGE_HEIGHT;
      centre_weight    <= rgblap_pkg::RESET_CENTRE_WEIGHT;
      neighbour_weight <= rgblap_pkg::RESET_NEIGHBOUR_WEIGHT;
    end else if (cfg_write) begin
      case (cfg_index)
        rgblap_pkg::REG_IMAGE_WIDTH:      image_width      <= cfg_data;
        rgblap_pkg::REG_IMAGE_HEIGHT:     image_height     <= cfg_data;
        rgblap_pkg::REG_CENTRE_WEIGHT:
          centre_weight <= cfg_data[rgblap_pkg::WEIGHT_W-1:0];
        rgblap_pkg::REG_NEIGHBOUR_WEIGHT:
          neighbour_weight <= cfg_data[rgblap_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated frame size
  always_comb begin
    width_raw  = WS_W'(image_width);
    height_raw = HS_W'(image_height);
    if (width_raw < W_MIN) begin
      w_eff = W_MIN;
    end else if (width_raw > W_MAX) begin
      w_eff = W_MAX;
    end else begin
      w_eff = width_raw;
    end
    if (height_raw < H_MIN) begin
      h_eff = H_MIN;
    end else if (height_raw > H_MAX) begin
      h_eff = H_MAX;
    end else begin
      h_eff = height_raw;
    end
  end

  // request decode against the current positions
  always_comb begin
    take        = in_valid && in_ready;
    in_row_ext  = HS_W'(in_row);
    in_frame    = in_row_ext < h_eff;
    in_col_inc  = WS_W'(in_column) + 1'b1;
    in_col_wrap = in_col_inc >= w_eff;
    active      = in_frame ? (kind == rgblap_pkg::KIND_PIXEL) : 1'b1;
    emit        = in_frame ? ((in_row >= ROW_W'(2)) ||
                              (in_row == ROW_W'(1) && in_column != '0)) : 1'b1;
    out_col_inc = WS_W'(out_column) + 1'b1;
    out_row_inc = HS_W'(out_row) + 1'b1;
    mask.up     = out_row != '0;
    mask.down   = out_row_inc < h_eff;
    mask.left   = out_column != '0;
    mask.right  = out_col_inc < w_eff;
    last        = !mask.down && !mask.right;
  end

  always_ff @(posedge clk) begin
    if (rst || size_write) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (take && active) begin
      if (emit && last) begin
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
      end else begin
        if (in_col_wrap) begin
          in_column <= '0;
          in_row    <= in_row + 1'b1;
        end else begin
          in_column <= in_column + 1'b1;
        end
        if (emit) begin
          if (!mask.right) begin
            out_column <= '0;
            out_row    <= out_row + 1'b1;
          end else begin
            out_column <= out_column + 1'b1;
          end
        end
      end
    end
  end

  assign in_ready = credit < rgblap_pkg::OQ_CNT_W'(rgblap_pkg::OQ_DEPTH);
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      case ({take && active && emit, pop})
        2'b10:   credit <= credit + 1'b1;
        2'b01:   credit <= credit - 1'b1;
        default: credit <= credit;
      endcase
    end
  end

  // stage 1: line buffer read returns, window shift and write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= take && active;
    end
    p1_pixel <= in_frame;
    p1_emit  <= emit;
    p1_last  <= last;
    p1_mask  <= mask;
    p1_pix   <= {red_in, green_in, blue_in};
    p1_col   <= in_column;
  end

  assign store_we = p1_valid && p1_pixel;

  rgblap_ram #(
    .WIDTH(rgblap_pkg::PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_row_upper (
    .clk  (clk),
    .we   (store_we),
    .waddr(p1_col),
    .wdata(rd_lower),
    .raddr(in_column),
    .rdata(rd_upper)
  );

  rgblap_ram #(
    .WIDTH(rgblap_pkg::PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_row_lower (
    .clk  (clk),
    .we   (store_we),
    .waddr(p1_col),
    .wdata(p1_pix),
    .raddr(in_column),
    .rdata(rd_lower)
  );

  always_comb begin
    col_in[0] = rd_upper;
    col_in[1] = rd_lower;
    col_in[2] = p1_pixel ? p1_pix : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        window_regs[i] <= '0;
      end
    end else if (p1_valid) begin
      for (int r = 0; r < 3; r++) begin
        window_regs[r * 3 + 0] <= window_regs[r * 3 + 1];
        window_regs[r * 3 + 1] <= window_regs[r * 3 + 2];
        window_regs[r * 3 + 2] <= col_in[r];
      end
    end
  end

  // stage 2: masked neighbour sums
  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid && p1_emit;
    end
    p2_last <= p1_last;
    p2_mask <= p1_mask;
  end

  always_comb begin
    tap_use = 1'b0;
    for (int ch = 0; ch < 3; ch++) begin
      nsum[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          tap_use = !(r == 1 && k == 1) &&
                    (r != 0 || p2_mask.up) && (r != 2 || p2_mask.down) &&
                    (k != 0 || p2_mask.left) && (k != 2 || p2_mask.right);
          if (tap_use) begin
            nsum[ch] = nsum[ch] + rgblap_pkg::NSUM_W'(
                       rgblap_pkg::chan_of(window_regs[r * 3 + k], ch));
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else begin
      p3_valid <= p2_valid;
    end
    p3_last <= p2_last;
    for (int ch = 0; ch < 3; ch++) begin
      p3_nsum[ch]   <= nsum[ch];
      p3_centre[ch] <= rgblap_pkg::chan_of(window_regs[4], ch);
    end
  end

  // stage 3: weighting, result goes into the output queue
  always_comb begin
    cw = rgblap_pkg::sat_weight(centre_weight);
    nw = rgblap_pkg::sat_weight(neighbour_weight);
    for (int ch = 0; ch < 3; ch++) begin
      prod_c[ch] = PROD_W'(cw) * $signed(PROD_W'(p3_centre[ch]));
      prod_n[ch] = PROD_W'(nw) * $signed(PROD_W'(p3_nsum[ch]));
      total[ch]  = prod_c[ch] + prod_n[ch];
    end
    push_data.red   = total[0][rgblap_pkg::SUM_W-1:0];
    push_data.green = total[1][rgblap_pkg::SUM_W-1:0];
    push_data.blue  = total[2][rgblap_pkg::SUM_W-1:0];
    push_data.last  = p3_last;
  end

  rgblap_fifo u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (p3_valid),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .not_empty(out_valid)
  );

  assign red_sum    = head.red;
  assign green_sum  = head.green;
  assign blue_sum   = head.blue;
  assign frame_last = head.last;

endmodule

>>> src/rgblap_checker.sv
// ----------------------------------------------------------------------------
// rgblap_checker
// Port-level checks for the RGB 3x3 Laplacian filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb_laplacian_3x3_filter_assert.svh"

module rgblap_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [rgblap_pkg::SUM_W-1:0] red_sum,
  input logic signed [rgblap_pkg::SUM_W-1:0] green_sum,
  input logic signed [rgblap_pkg::SUM_W-1:0] blue_sum,
  input logic                                frame_last
);

  // a waiting result is held
  `RGBLAP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `RGBLAP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(red_sum) && $stable(green_sum) && $stable(blue_sum) && $stable(frame_last))

  // nothing pending and ready right after reset
  `RGBLAP_ASSERT_SAME(a_reset_clear, $past(rst), !out_valid && in_ready)

  // saturated weights bound every sum
  `RGBLAP_ASSERT_SAME(a_sum_range, out_valid, red_sum >= -36720 && red_sum <= 36720 && green_sum >= -36720 && green_sum <= 36720 && blue_sum >= -36720 && blue_sum <= 36720)

endmodule

bind rgb_laplacian_3x3_filter rgblap_checker u_checker (.*);

>>> sim/rgb_laplacian_3x3_filter_tb.sv
// ----------------------------------------------------------------------------
// rgb_laplacian_3x3_filter_tb
// Self-checking bench for the streaming RGB 3x3 filter. Frames of pixels and
// flush requests go in through a queue-fed driver. A predictor
// keeps its own line stores, window, counters and register copies, and
// builds the expected channel sums for every accepted request. A monitor
// compares each result with the oldest expected one, field by field. Sizes
// and weights are changed between phases, out-of-range codes among them.
// Both sides idle at random, and a long output hold makes the input stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rgb_laplacian_3x3_filter_tb;

  localparam int unsigned LINE_MAX = 1024;
  localparam int unsigned ROWS_MAX = 1024;
  localparam int          LINE_IDX_W = $clog2(LINE_MAX);

  typedef logic [rgblap_pkg::CFG_DATA_W-1:0]   cfg_word_t;
  typedef logic [rgblap_pkg::WEIGHT_W-1:0]     weight_t;
  typedef logic [rgblap_pkg::CH_W-1:0]         chan_t;
  typedef logic signed [rgblap_pkg::SUM_W-1:0] sum_t;

  typedef struct {
    rgblap_pkg::kind_t kind;
    rgblap_pkg::pix_t  pix;
  } request_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  rgblap_pkg::reg_index_t cfg_index = rgblap_pkg::REG_IMAGE_WIDTH;
  cfg_word_t              cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  rgblap_pkg::kind_t      kind = rgblap_pkg::KIND_PIXEL;
  chan_t                  red_in = '0;
  chan_t                  green_in = '0;
  chan_t                  blue_in = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b1;
  sum_t                   red_sum;
  sum_t                   green_sum;
  sum_t                   blue_sum;
  logic                   frame_last;

  // stimulus and checking bookkeeping
  request_t             pending_requests[$];
  rgblap_pkg::result_t  expected_sums[$];
  int unsigned pushed_count = 0;
  int unsigned accepted_count = 0;
  int unsigned counted_items = 0;
  int          fail_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  bit          quiet = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_left = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_done = 0;

  // predictor state
  cfg_word_t             width_reg = rgblap_pkg::RESET_IMAGE_WIDTH;
  cfg_word_t             height_reg = rgblap_pkg::RESET_IMAGE_HEIGHT;
  weight_t               centre_reg = rgblap_pkg::RESET_CENTRE_WEIGHT;
  weight_t               neighbour_reg = rgblap_pkg::RESET_NEIGHBOUR_WEIGHT;
  rgblap_pkg::pix_t      upper_row [LINE_MAX];
  rgblap_pkg::pix_t      lower_row [LINE_MAX];
  rgblap_pkg::pix_t      nbhd [9];
  int unsigned           col_in = 0;
  int unsigned           row_in = 0;
  int unsigned           col_out = 0;
  int unsigned           row_out = 0;

  rgb_laplacian_3x3_filter DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .red_in     (red_in),
    .green_in   (green_in),
    .blue_in    (blue_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red_sum    (red_sum),
    .green_sum  (green_sum),
    .blue_sum   (blue_sum),
    .frame_last (frame_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int sat_coeff(input weight_t bits);
    int v;
    v = int'($signed(bits));
    if (v < -16) return -16;
    if (v > 16) return 16;
    return v;
  endfunction

  function automatic void restart_counters();
    col_in = 0;
    row_in = 0;
    col_out = 0;
    row_out = 0;
  endfunction

  task automatic convolve_request(input rgblap_pkg::kind_t req_kind,
                                  input rgblap_pkg::pix_t pix);
    int unsigned w, h, c;
    logic [LINE_IDX_W-1:0] ci;
    rgblap_pkg::pix_t top, mid, bot;
    rgblap_pkg::pix_t column [3];
    bit in_frame, emit, up_ok, down_ok, left_ok, right_ok;
    int cw, nw, nsum, total, r, j, ch;
    sum_t sums [3];
    rgblap_pkg::result_t res;
    w = clamp_size(width_reg, LINE_MAX);
    h = clamp_size(height_reg, ROWS_MAX);
    c = col_in;
    ci = c[LINE_IDX_W-1:0];
    top = upper_row[ci];
    mid = lower_row[ci];
    in_frame = row_in < h;
    // flush before the frame's last pixel, or when idle
    if (in_frame && req_kind == rgblap_pkg::KIND_FLUSH) return;
    emit = !in_frame || row_in >= 2 || (row_in == 1 && c >= 1);
    // beyond the last row every request is a flush tick
    bot = in_frame ? pix : '0;
    if (in_frame) begin
      upper_row[ci] = mid;
      lower_row[ci] = bot;
    end
    column[0] = top;
    column[1] = mid;
    column[2] = bot;
    for (r = 0; r < 3; r++) begin
      nbhd[r * 3] = nbhd[r * 3 + 1];
      nbhd[r * 3 + 1] = nbhd[r * 3 + 2];
      nbhd[r * 3 + 2] = column[r];
    end
    if (c + 1 >= w) begin
      col_in = 0;
      row_in++;
    end else begin
      col_in = c + 1;
    end
    if (!emit) return;

    up_ok = row_out > 0;
    down_ok = row_out + 1 < h;
    left_ok = col_out > 0;
    right_ok = col_out + 1 < w;
    cw = sat_coeff(centre_reg);
    nw = sat_coeff(neighbour_reg);
    for (ch = 0; ch < 3; ch++) begin
      nsum = 0;
      for (r = 0; r < 3; r++) begin
        for (j = 0; j < 3; j++) begin
          if ((r == 0 && !up_ok) || (r == 2 && !down_ok) || (j == 0 && !left_ok) ||
              (j == 2 && !right_ok) || (r == 1 && j == 1)) continue;
          nsum += int'(nbhd[r * 3 + j][16 - 8 * ch +: 8]);
        end
      end
      total = cw * int'(nbhd[4][16 - 8 * ch +: 8]) + nw * nsum;
      sums[ch] = total[rgblap_pkg::SUM_W-1:0];
    end
    res.red = sums[0];
    res.green = sums[1];
    res.blue = sums[2];
    res.last = (row_out + 1 >= h) && (col_out + 1 >= w);
    expected_sums.push_back(res);
    if (res.last) begin
      restart_counters();
    end else if (col_out + 1 >= w) begin
      col_out = 0;
      row_out++;
    end else begin
      col_out++;
    end
  endtask

  // register writes and accepted requests feed the predictor
  always @(posedge clk) begin : accept
    if (!rst) begin
      if (cfg_write) begin
        case (cfg_index)
          rgblap_pkg::REG_IMAGE_WIDTH:      width_reg = cfg_data;
          rgblap_pkg::REG_IMAGE_HEIGHT:     height_reg = cfg_data;
          rgblap_pkg::REG_CENTRE_WEIGHT:    centre_reg = cfg_data[rgblap_pkg::WEIGHT_W-1:0];
          rgblap_pkg::REG_NEIGHBOUR_WEIGHT:
            neighbour_reg = cfg_data[rgblap_pkg::WEIGHT_W-1:0];
          default: ;
        endcase
        if (cfg_index == rgblap_pkg::REG_IMAGE_WIDTH ||
            cfg_index == rgblap_pkg::REG_IMAGE_HEIGHT) restart_counters();
      end
      if (in_valid && in_ready) begin
        accepted_count++;
        convolve_request(kind, {red_in, green_in, blue_in});
      end
    end
  end

  always @(posedge clk) begin : drive
    request_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(99) < idle_pct) begin
        send_gap <= $urandom_range(18, 0);
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        nxt = pending_requests.pop_front();
        kind <= nxt.kind;
        red_in <= nxt.pix[23:16];
        green_in <= nxt.pix[15:8];
        blue_in <= nxt.pix[7:0];
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : drain
    if (rst) begin
      out_ready <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (holds_done != hold_requests) begin
      // long hold so the output queue fills and the input stalls
      holds_done <= holds_done + 1;
      hold_left <= 299;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(99) < stall_pct) begin
      recv_gap <= $urandom_range(18, 0);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void compare_field(input string field, input sum_t want, input sum_t got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin : check
    rgblap_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_sums.size() == 0) begin
        fail_count++;
        $display("%0t: result with none expected: red_sum %0d green_sum %0d blue_sum %0d",
                 $time, red_sum, green_sum, blue_sum);
      end else begin
        want = expected_sums.pop_front();
        compare_field("red_sum", want.red, red_sum);
        compare_field("green_sum", want.green, green_sum);
        compare_field("blue_sum", want.blue, blue_sum);
        compare_field("frame_last", sum_t'(want.last), sum_t'(frame_last));
      end
    end
  end

  task automatic write_reg(input rgblap_pkg::reg_index_t idx, input cfg_word_t value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic push_request(input rgblap_pkg::kind_t req_kind, input rgblap_pkg::pix_t pix);
    request_t req;
    req.kind = req_kind;
    req.pix = pix;
    pending_requests.push_back(req);
    pushed_count++;
  endtask

  // wait until every request is taken and every result is back
  task automatic settle();
    do @(posedge clk);
    while (accepted_count != pushed_count || expected_sums.size() != 0);
    repeat (16) @(posedge clk);
  endtask

  function automatic rgblap_pkg::pix_t pick_pixel(input int style);
    rgblap_pkg::pix_t p;
    int i;
    p = rgblap_pkg::pix_t'($urandom);
    if (style == 1) begin
      for (i = 0; i < 3; i++) p[8 * i +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
    end
    return p;
  endfunction

  task automatic feed_frame(input int w, input int h, input int pixels, input int style,
                            input int pause_at);
    int n;
    for (n = 0; n < pixels; n++) begin
      if (n == pause_at) settle();
      if ($urandom_range(99) < 3) begin
        push_request(rgblap_pkg::KIND_FLUSH, rgblap_pkg::pix_t'($urandom));
      end
      push_request(rgblap_pkg::KIND_PIXEL, pick_pixel(style));
      counted_items++;
    end
    if (pixels == w * h) begin
      // trailing ticks, pixels among them act as flush
      for (n = 0; n <= w; n++) begin
        push_request($urandom_range(1) ? rgblap_pkg::KIND_FLUSH : rgblap_pkg::KIND_PIXEL,
                     rgblap_pkg::pix_t'($urandom));
        counted_items++;
      end
    end
  endtask

  function automatic int pick_pct();
    case ($urandom_range(3))
      0: return 0;
      1: return 5;
      2: return 15;
      default: return 40;
    endcase
  endfunction

  initial begin : stimulus
    int n, f, frames, phase, w, h, style;
    cfg_word_t w_code, h_code;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // largest positive sum, out-of-range weight codes
    write_reg(rgblap_pkg::REG_IMAGE_WIDTH, 11'd3);
    write_reg(rgblap_pkg::REG_IMAGE_HEIGHT, 11'd3);
    write_reg(rgblap_pkg::REG_CENTRE_WEIGHT, 11'h01F);
    write_reg(rgblap_pkg::REG_NEIGHBOUR_WEIGHT, 11'h011);
    hold_requests++;
    push_request(rgblap_pkg::KIND_FLUSH, '1);
    for (n = 0; n < 9; n++) begin
      if (n == 4) push_request(rgblap_pkg::KIND_FLUSH, '0);
      push_request(rgblap_pkg::KIND_PIXEL, 24'hFFFFFF);
    end
    for (n = 0; n < 4; n++) begin
      push_request(n[0] ? rgblap_pkg::KIND_PIXEL : rgblap_pkg::KIND_FLUSH, 24'hA5A5A5);
    end
    settle();

    // large negative sums, weight codes below range
    write_reg(rgblap_pkg::REG_CENTRE_WEIGHT, 11'h020);
    write_reg(rgblap_pkg::REG_NEIGHBOUR_WEIGHT, 11'h02F);
    for (n = 0; n < 9; n++) begin
      push_request(rgblap_pkg::KIND_PIXEL, (n == 7) ? 24'h000000 : 24'hFFFFFF);
    end
    for (n = 0; n < 4; n++) push_request(rgblap_pkg::KIND_FLUSH, 24'h5A5A5A);
    settle();

    counted_items = 0;
    phase = 0;
    while (counted_items < 250) begin
      phase++;
      w_code = ($urandom_range(9) == 0) ? cfg_word_t'($urandom_range(1)) :
                                          cfg_word_t'($urandom_range(12, 2));
      h_code = ($urandom_range(9) == 0) ? cfg_word_t'($urandom_range(1)) :
                                          cfg_word_t'($urandom_range(8, 2));
      w = clamp_size(w_code, LINE_MAX);
      h = clamp_size(h_code, ROWS_MAX);
      write_reg(rgblap_pkg::REG_IMAGE_WIDTH, w_code);
      write_reg(rgblap_pkg::REG_IMAGE_HEIGHT, h_code);
      if ($urandom_range(3) == 0) begin
        write_reg(rgblap_pkg::REG_CENTRE_WEIGHT, 11'(rgblap_pkg::RESET_CENTRE_WEIGHT));
        write_reg(rgblap_pkg::REG_NEIGHBOUR_WEIGHT, 11'(rgblap_pkg::RESET_NEIGHBOUR_WEIGHT));
      end else begin
        write_reg(rgblap_pkg::REG_CENTRE_WEIGHT, 11'($urandom));
        write_reg(rgblap_pkg::REG_NEIGHBOUR_WEIGHT, 11'($urandom));
      end
      idle_pct = pick_pct();
      stall_pct = pick_pct();
      if (phase % 8 == 1) begin
        idle_pct = 0;
        hold_requests++;
      end
      frames = $urandom_range(3, 1);
      for (f = 0; f < frames; f++) begin
        style = $urandom_range(1);
        if ($urandom_range(5) == 0) begin
          // broken frame, cut short by the next size write
          feed_frame(w, h, $urandom_range(w * h - 1, 1), style, -1);
          break;
        end
        feed_frame(w, h, w * h, style, ($urandom_range(4) == 0) ? (w * h / 2) : -1);
        if ($urandom_range(3) == 0) begin
          for (n = $urandom_range(3, 1); n > 0; n--) begin
            push_request(rgblap_pkg::KIND_FLUSH, rgblap_pkg::pix_t'($urandom));
          end
        end
      end
      settle();
    end

    // widest line, width code above range, height code below, cut short
    write_reg(rgblap_pkg::REG_IMAGE_WIDTH, 11'h7FF);
    write_reg(rgblap_pkg::REG_IMAGE_HEIGHT, 11'd1);
    write_reg(rgblap_pkg::REG_CENTRE_WEIGHT, 11'($urandom));
    write_reg(rgblap_pkg::REG_NEIGHBOUR_WEIGHT, 11'($urandom));
    idle_pct = 10;
    stall_pct = 10;
    feed_frame(1024, 2, 1040, 0, -1);
    settle();

    write_reg(rgblap_pkg::REG_IMAGE_WIDTH, 11'd3);
    write_reg(rgblap_pkg::REG_IMAGE_HEIGHT, 11'h7FF);
    feed_frame(3, 1024, 30, 0, -1);
    settle();

    // closing part runs without idling
    quiet = 1'b1;
    write_reg(rgblap_pkg::REG_IMAGE_WIDTH, 11'd6);
    write_reg(rgblap_pkg::REG_IMAGE_HEIGHT, 11'd4);
    write_reg(rgblap_pkg::REG_CENTRE_WEIGHT, 11'(rgblap_pkg::RESET_CENTRE_WEIGHT));
    write_reg(rgblap_pkg::REG_NEIGHBOUR_WEIGHT, 11'(rgblap_pkg::RESET_NEIGHBOUR_WEIGHT));
    feed_frame(6, 4, 24, 0, -1);
    feed_frame(6, 4, 24, 1, -1);
    settle();

    if (expected_sums.size() != 0) begin
      fail_count++;
      $display("%0t: %0d expected results never arrived", $time, expected_sums.size());
    end
    if (fail_count == 0) begin
      $display("rgb_laplacian_3x3_filter regression: pass");
    end else begin
      $display("rgb_laplacian_3x3_filter regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("rgb_laplacian_3x3_filter regression: fail");
    $finish;
  end

endmodule
